[hdl/tas_pkg.sv]
// Shared types, constants and codes for the texture albedo sampler.
`default_nettype none

package tas_pkg;

   // Fixed field widths
   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 16;
   localparam int RGB_W       = 24;
   localparam int CHAN_W      = 8;
   localparam int DIM_W       = 9;
   localparam int DENSITY_W   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF         = 256;
   localparam int COORD_FRAC_BITS_DEF = 16;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Fallback colour
   localparam logic [RGB_W-1:0] RED_RGB = 24'hFF0000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COLOR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_COLOR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd5;

   // Request function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      MODE_RED     = 2'd0,
      MODE_SOLID   = 2'd1,
      MODE_CHECKER = 2'd2,
      MODE_IMAGE   = 2'd3
   } mode_type;

   // What the back part has to do with an item
   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_COLOUR  = 2'd1,
      KIND_CHECKER = 2'd2,
      KIND_LOOKUP  = 2'd3
   } kind_type;

   // Configuration as seen by front and back (dimensions already saturated)
   typedef struct packed {
      mode_type               mode;
      logic [DENSITY_W-1:0]   density;
      logic [RGB_W-1:0]       first_color;
      logic [RGB_W-1:0]       second_color;
      logic [DIM_W-1:0]       width;
      logic [DIM_W-1:0]       height;
   } cfg_type;

   // Fixed part of a queue entry
   typedef struct packed {
      kind_type               kind;
      logic [RGB_W-1:0]       rgb;
      logic [INDEX_W-1:0]     index;
   } head_type;

endpackage

`default_nettype wire

[hdl/tas_if.sv]
// Valid/ready channel interfaces for sampler requests and responses.
`default_nettype none

interface tas_req_if import tas_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic [INDEX_W-1:0]        texel_index;
   logic [RGB_W-1:0]          texel_rgb;

   modport source (output valid, func, coord_x, coord_y, texel_index, texel_rgb,
                   input ready);
   modport sink   (input valid, func, coord_x, coord_y, texel_index, texel_rgb,
                   output ready);
endinterface

interface tas_rsp_if import tas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

[hdl/tas_front.sv]
// Front part: accepts requests, classifies them, clamps coordinates, resolves the checker.
`default_nettype none

module tas_front import tas_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tas_req_if.sink                         req_chan,
   input  wire cfg_type                    cfg,
   output logic                            push_valid,
   input  wire logic                       push_ready,
   output head_type                        push_head,
   output logic [COORD_FRAC_BITS:0]        push_cx,
   output logic [COORD_FRAC_BITS:0]        push_cy
);

   localparam int CW     = COORD_FRAC_BITS + 1;
   localparam int FB     = COORD_FRAC_BITS + 8;
   localparam int WIDE_W = COORD_W + 2;
   localparam logic signed [WIDE_W-1:0] ONE_WIDE = WIDE_W'(64'd1 << COORD_FRAC_BITS);
   localparam logic [FB-1:0] HALF = FB'(64'd1 << (FB - 1));

   // clamp to the unit interval
   function automatic logic [CW-1:0] clamp_unit(input logic signed [WIDE_W-1:0] c);
      logic [CW-1:0] r;
      if (c < 0) begin
         r = '0;
      end else if (c > ONE_WIDE) begin
         r = CW'(ONE_WIDE);
      end else begin
         r = c[CW-1:0];
      end
      return r;
   endfunction

   logic                      f_valid_ff, f_valid_in;
   head_type                  f_head_ff, f_head_in;
   logic [FB-1:0]             f_tx_ff, f_ty_ff;
   logic [CW-1:0]             f_cx_ff, f_cy_ff;

   logic                      load;
   logic                      push;
   logic signed [WIDE_W-1:0]  x_wide, y_wide, y_flip;
   logic [FB+DENSITY_W-1:0]   tx_full, ty_full;
   logic                      nz_x, nz_y, hit;

   assign push             = f_valid_ff && push_ready;
   assign req_chan.ready   = !f_valid_ff || push_ready;
   assign load             = req_chan.valid && req_chan.ready;

   // coordinates widened so that 1 - y cannot overflow
   assign x_wide = WIDE_W'(req_chan.coord_x);
   assign y_wide = WIDE_W'(req_chan.coord_y);
   assign y_flip = ONE_WIDE - y_wide;

   // checker phase: only the fraction bits of density * coordinate matter
   assign tx_full = req_chan.coord_x[FB-1:0] * cfg.density;
   assign ty_full = req_chan.coord_y[FB-1:0] * cfg.density;

   // classification
   always_comb begin
      f_head_in.kind  = KIND_COLOUR;
      f_head_in.rgb   = RED_RGB;
      f_head_in.index = req_chan.texel_index;
      if (req_chan.func == FUNC_WRITE) begin
         f_head_in.kind = KIND_WRITE;
         f_head_in.rgb  = req_chan.texel_rgb;
      end else begin
         case (cfg.mode)
            MODE_SOLID: begin
               f_head_in.rgb = cfg.first_color;
            end
            MODE_CHECKER: begin
               f_head_in.kind = KIND_CHECKER;
            end
            MODE_IMAGE: begin
               if (cfg.width != '0 && cfg.height != '0) begin
                  f_head_in.kind = KIND_LOOKUP;
               end
            end
            default: begin
               f_head_in.rgb = RED_RGB;
            end
         endcase
      end
   end

   always_comb begin
      f_valid_in = f_valid_ff;
      if (load) begin
         f_valid_in = 1'b1;
      end else if (push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         f_head_ff <= f_head_in;
         f_tx_ff   <= tx_full[FB-1:0];
         f_ty_ff   <= ty_full[FB-1:0];
         f_cx_ff   <= clamp_unit(x_wide);
         f_cy_ff   <= clamp_unit(y_flip);
      end
   end

   // checker sign: colour one when exactly one sine is negative and none is zero
   assign nz_x = (f_tx_ff != '0) && (f_tx_ff != HALF);
   assign nz_y = (f_ty_ff != '0) && (f_ty_ff != HALF);
   assign hit  = nz_x && nz_y && (f_tx_ff[FB-1] ^ f_ty_ff[FB-1]);

   always_comb begin
      push_head = f_head_ff;
      if (f_head_ff.kind == KIND_CHECKER) begin
         push_head.kind = KIND_COLOUR;
         push_head.rgb  = hit ? cfg.first_color : cfg.second_color;
      end
   end

   assign push_valid = f_valid_ff;
   assign push_cx    = f_cx_ff;
   assign push_cy    = f_cy_ff;

endmodule

`default_nettype wire

[hdl/tas_queue.sv]
// Short register queue that decouples the front part from the back part.
`default_nettype none

module tas_queue import tas_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (!reset && push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on a lone push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (!reset && pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on a lone pop");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

[hdl/tas_back.sv]
// Back part: texel coordinate pipeline, texel store and response register.
`default_nettype none

module tas_back import tas_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     pop_valid,
   output logic                          pop_ready,
   input  wire head_type                 pop_head,
   input  wire logic [COORD_FRAC_BITS:0] pop_cx,
   input  wire logic [COORD_FRAC_BITS:0] pop_cy,
   tas_rsp_if.source                     rsp_chan
);

   localparam int CW          = COORD_FRAC_BITS + 1;
   localparam int PROD_W      = CW + DIM_W;
   localparam int STORE_DEPTH = 2 ** INDEX_W;

   logic                  adv;

   // stage 1: scaled coordinates
   logic                  s1_valid_ff;
   head_type              s1_head_ff;
   logic [PROD_W-1:0]     s1_pu_ff, s1_pv_ff;

   // stage 2: column and row offset
   logic                  s2_valid_ff;
   head_type              s2_head_ff;
   logic [DIM_W-1:0]      s2_u_ff;
   logic [2*DIM_W-1:0]    s2_vw_ff;

   // output stage
   logic                  o_valid_ff;
   logic                  o_lookup_ff;
   logic [RGB_W-1:0]      o_rgb_ff;
   logic [RGB_W-1:0]      rd_ff;

   logic [RGB_W-1:0]      store [STORE_DEPTH];

   logic [DIM_W:0]        iu, iv, wm1, hm1;
   logic [DIM_W-1:0]      u_in, v_in;
   logic [2*DIM_W-1:0]    vw_in, addr_sum;
   logic [INDEX_W-1:0]    addr;
   logic [RGB_W-1:0]      colour;

   // whole pipeline moves when the response register is free or being drained
   assign adv       = !o_valid_ff || rsp_chan.ready;
   assign pop_ready = adv;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
         o_valid_ff  <= s2_valid_ff && (s2_head_ff.kind != KIND_WRITE);
      end
   end

   // stage 1: coordinate times dimension
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_head_ff <= pop_head;
         s1_pu_ff   <= pop_cx * cfg.width;
         s1_pv_ff   <= pop_cy * cfg.height;
      end
   end

   // stage 2: floor, limit to dimension - 1, row offset
   assign iu   = s1_pu_ff[COORD_FRAC_BITS +: DIM_W+1];
   assign iv   = s1_pv_ff[COORD_FRAC_BITS +: DIM_W+1];
   assign wm1  = {1'b0, cfg.width} - 1'b1;
   assign hm1  = {1'b0, cfg.height} - 1'b1;
   assign u_in = (iu > wm1) ? wm1[DIM_W-1:0] : iu[DIM_W-1:0];
   assign v_in = (iv > hm1) ? hm1[DIM_W-1:0] : iv[DIM_W-1:0];
   assign vw_in = v_in * cfg.width;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_head_ff <= s1_head_ff;
         s2_u_ff    <= u_in;
         s2_vw_ff   <= vw_in;
      end
   end

   // stage 3: store address, wrapped to the store size
   assign addr_sum = s2_vw_ff + {{DIM_W{1'b0}}, s2_u_ff};
   assign addr     = (s2_head_ff.kind == KIND_LOOKUP) ? addr_sum[INDEX_W-1:0]
                                                      : s2_head_ff.index;

   // texel store write port
   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff && s2_head_ff.kind == KIND_WRITE) begin
         store[addr] <= s2_head_ff.rgb;
      end
   end

   // texel store read port, registered
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= store[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_lookup_ff <= (s2_head_ff.kind == KIND_LOOKUP);
         o_rgb_ff    <= s2_head_ff.rgb;
      end
   end

   // response
   assign colour         = o_lookup_ff ? rd_ff : o_rgb_ff;
   assign rsp_chan.valid = o_valid_ff;
   assign rsp_chan.red   = colour[23:16];
   assign rsp_chan.green = colour[15:8];
   assign rsp_chan.blue  = colour[7:0];

endmodule

`default_nettype wire

[hdl/texture_albedo_sampler_core.sv]
// Top level of the texture albedo sampler: registers, front, queue and back.
`default_nettype none

// The sampler takes one request per cycle unless back-pressure holds it, and
// returns one colour per sample request; texel writes return nothing. A sample
// passes the front register, queue, scale and offset stages and the response
// register holding the registered texel store read. Sustained rate is one item
// per cycle while the response side accepts, set by the single write/read
// port of the 65536 x 24-bit texel store that both writes and lookups pass
// through in order. A texel must be written before it is looked up; the store
// has no reset and no clearing pass. The user must write registers through the
// csr_ port only while no item is in flight; the block does not enforce this.
// Image dimensions above MAX_DIM are saturated to MAX_DIM.
module texture_albedo_sampler_core import tas_pkg::*; #(
   parameter int MAX_DIM         = MAX_DIM_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   tas_req_if.sink                     req_chan,
   tas_rsp_if.source                   rsp_chan
);

   localparam int CW      = COORD_FRAC_BITS + 1;
   localparam int DIM_TOP = (1 << DIM_W) - 1;
   localparam int SAT_INT = (MAX_DIM > DIM_TOP) ? DIM_TOP : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(SAT_INT);
   localparam int Q_W     = $bits(head_type) + 2 * CW;

   mode_type             mode_ff;
   logic [DENSITY_W-1:0] density_ff;
   logic [RGB_W-1:0]     first_color_ff;
   logic [RGB_W-1:0]     second_color_ff;
   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   cfg_type              cfg;

   logic                 f_push_valid, f_push_ready;
   head_type             f_push_head;
   logic [CW-1:0]        f_push_cx, f_push_cy;
   logic                 b_pop_valid, b_pop_ready;
   logic [Q_W-1:0]       q_push_data, q_pop_data;
   head_type             b_pop_head;
   logic [CW-1:0]        b_pop_cx, b_pop_cy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_SOLID;
         density_ff      <= 16'd256;
         first_color_ff  <= '0;
         second_color_ff <= 24'hFFFFFF;
         width_ff        <= '0;
         height_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:         mode_ff         <= mode_type'(csr_wdata[1:0]);
            CSR_DENSITY:      density_ff      <= csr_wdata[DENSITY_W-1:0];
            CSR_FIRST_COLOR:  first_color_ff  <= csr_wdata[RGB_W-1:0];
            CSR_SECOND_COLOR: second_color_ff <= csr_wdata[RGB_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff        <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff       <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // dimensions saturated to MAX_DIM
   always_comb begin
      cfg.mode         = mode_ff;
      cfg.density      = density_ff;
      cfg.first_color  = first_color_ff;
      cfg.second_color = second_color_ff;
      cfg.width        = (width_ff > DIM_SAT) ? DIM_SAT : width_ff;
      cfg.height       = (height_ff > DIM_SAT) ? DIM_SAT : height_ff;
   end

   tas_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_head  (f_push_head),
      .push_cx    (f_push_cx),
      .push_cy    (f_push_cy)
   );

   assign q_push_data = {f_push_head, f_push_cx, f_push_cy};

   tas_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (b_pop_valid),
      .pop_ready  (b_pop_ready),
      .pop_data   (q_pop_data)
   );

   assign {b_pop_head, b_pop_cx, b_pop_cy} = q_pop_data;

   tas_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (b_pop_valid),
      .pop_ready (b_pop_ready),
      .pop_head  (b_pop_head),
      .pop_cx    (b_pop_cx),
      .pop_cy    (b_pop_cy),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[dv/texture_albedo_sampler_core_tb.sv]
// Self-checking testbench for the texture albedo sampler core: directed table, then random phases.

module texture_albedo_sampler_core_tb;
   import tas_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int IDLE_PERCENT  = 19;
   localparam int DENSITY_FRAC  = 8;
   localparam int SINE_FRAC     = DENSITY_FRAC + COORD_FRAC_BITS_DEF;
   localparam longint COORD_ONE = longint'(1) << COORD_FRAC_BITS_DEF;

   typedef enum logic {ROW_REG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      logic                   func;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      logic [INDEX_W-1:0]     index;
      logic [RGB_W-1:0]       rgb;
      bit                     typed;
      logic [RGB_W-1:0]       colour;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tas_req_if req_bus ();
   tas_rsp_if rsp_bus ();

   texture_albedo_sampler_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Predictor copy of the registers and the texel store
   mode_type             cfg_mode;
   logic [DENSITY_W-1:0] cfg_density;
   logic [RGB_W-1:0]     cfg_first;
   logic [RGB_W-1:0]     cfg_second;
   logic [DIM_W-1:0]     cfg_width;
   logic [DIM_W-1:0]     cfg_height;
   logic [RGB_W-1:0]     texel_copy [0:(1<<INDEX_W)-1];
   bit                   texel_written [0:(1<<INDEX_W)-1];

   logic [RGB_W-1:0] colour_q [$];
   stim_row_type     dir_rows [$];

   int  n_errors;
   int  n_checked;
   int  n_writes;
   int  n_samples;
   int  n_settings;
   int  cycle_count;
   bit  quiet;
   bit  hold_req;
   int  hold_left;
   logic [RGB_W-1:0] want;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d colours still outstanding", $time, colour_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_req) begin
         hold_req      = 1'b0;
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
      end else begin
         rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Compare each response transfer with the oldest expected colour
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (colour_q.size() == 0) begin
            $display("%0t: response %h %h %h with no colour expected", $time,
                     rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            n_errors++;
         end else begin
            want = colour_q.pop_front();
            n_checked++;
            if (rsp_bus.red !== want[23:16]) begin
               $display("%0t: red expected %h, got %h", $time, want[23:16], rsp_bus.red);
               n_errors++;
            end
            if (rsp_bus.green !== want[15:8]) begin
               $display("%0t: green expected %h, got %h", $time, want[15:8], rsp_bus.green);
               n_errors++;
            end
            if (rsp_bus.blue !== want[7:0]) begin
               $display("%0t: blue expected %h, got %h", $time, want[7:0], rsp_bus.blue);
               n_errors++;
            end
         end
      end
   end

   function automatic int dim_sat(logic [DIM_W-1:0] d);
      return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
   endfunction

   // Sign of the checker sine: 0 on a zero crossing, -1 in the upper half period
   function automatic int sine_sign(logic [COORD_W-1:0] c);
      logic [COORD_W-1:0]   t;
      logic [SINE_FRAC-1:0] frac;
      t    = c * {{(COORD_W-DENSITY_W){1'b0}}, cfg_density};
      frac = t[SINE_FRAC-1:0];
      if (frac == '0 || frac == (1 << (SINE_FRAC-1)))
         return 0;
      return frac[SINE_FRAC-1] ? -1 : 1;
   endfunction

   function automatic int nearest_texel(longint c, int dim);
      longint i;
      if (c < 0)
         c = 0;
      if (c > COORD_ONE)
         c = COORD_ONE;
      i = (c * dim) >>> COORD_FRAC_BITS_DEF;
      if (i > dim - 1)
         i = dim - 1;
      return int'(i);
   endfunction

   // Store address hit by a lookup; y runs upwards, so rows count from 1-y
   function automatic logic [INDEX_W-1:0] texel_addr(logic [COORD_W-1:0] x, y);
      int w;
      int h;
      int u;
      int v;
      w = dim_sat(cfg_width);
      h = dim_sat(cfg_height);
      u = nearest_texel(longint'($signed(x)), w);
      v = nearest_texel(COORD_ONE - longint'($signed(y)), h);
      return INDEX_W'(v * w + u);
   endfunction

   function automatic logic [RGB_W-1:0] predict_colour(logic [COORD_W-1:0] x, y);
      case (cfg_mode)
         MODE_SOLID: begin
            return cfg_first;
         end
         MODE_CHECKER: begin
            return (sine_sign(x) * sine_sign(y) < 0) ? cfg_first : cfg_second;
         end
         MODE_IMAGE: begin
            if (dim_sat(cfg_width) == 0 || dim_sat(cfg_height) == 0)
               return RED_RGB;
            return texel_copy[texel_addr(x, y)];
         end
         default: begin
            return RED_RGB;
         end
      endcase
   endfunction

   // Coordinate mostly in [-1/8, 1+1/8], with the clamp edges and full range mixed in
   function automatic logic [COORD_W-1:0] span_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return $urandom;
      if (pick == 1)
         return $urandom_range(0, 1) ? 32'h0 : 32'(COORD_ONE);
      return 32'(int'($urandom_range(0, 32'h14000)) - 32'sh2000);
   endfunction

   // Offer one item and wait for its transfer, then record what it implies
   task automatic send_item(logic f, logic [COORD_W-1:0] x, y, logic [INDEX_W-1:0] index,
                            logic [RGB_W-1:0] rgb, bit typed, logic [RGB_W-1:0] colour);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.coord_x     <= x;
      req_bus.coord_y     <= y;
      req_bus.texel_index <= index;
      req_bus.texel_rgb   <= rgb;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (f == FUNC_WRITE) begin
         texel_copy[index]    = rgb;
         texel_written[index] = 1'b1;
         n_writes++;
      end else begin
         colour_q.push_back(typed ? colour : predict_colour(x, y));
         n_samples++;
      end
   endtask

   // Each further idle cycle is taken with the same chance, about 19 in a hundred overall
   task automatic idle_gap();
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (colour_q.size() != 0)
         @(posedge clock);
   endtask

   // Register write, only once the pipeline has emptied (writes leave no trace)
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_MODE:         cfg_mode    = mode_type'(data[1:0]);
         CSR_DENSITY:      cfg_density = data[DENSITY_W-1:0];
         CSR_FIRST_COLOR:  cfg_first   = data[RGB_W-1:0];
         CSR_SECOND_COLOR: cfg_second  = data[RGB_W-1:0];
         CSR_IMAGE_WIDTH:  cfg_width   = data[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height  = data[DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic add_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r           = '{kind: ROW_REG, default: '0};
      r.reg_index = index;
      r.reg_data  = data;
      dir_rows.push_back(r);
   endtask

   task automatic add_item(logic f, logic [COORD_W-1:0] x, y, logic [INDEX_W-1:0] index,
                           logic [RGB_W-1:0] rgb, bit typed, logic [RGB_W-1:0] colour);
      stim_row_type r;
      r        = '{kind: ROW_ITEM, default: '0};
      r.func   = f;
      r.x      = x;
      r.y      = y;
      r.index  = index;
      r.rgb    = rgb;
      r.typed  = typed;
      r.colour = colour;
      dir_rows.push_back(r);
   endtask

   // One register setting followed by a stream of random transfers
   task automatic run_phase(mode_type m, logic [DENSITY_W-1:0] dens,
                            logic [RGB_W-1:0] c1, c2, logic [DIM_W-1:0] w, h,
                            int count, bit hold, bit pause);
      logic               f;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INDEX_W-1:0] index;
      logic [INDEX_W-1:0] target;
      int                 area;
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      write_reg(CSR_DENSITY, CSR_DATA_W'(dens));
      write_reg(CSR_FIRST_COLOR, c1);
      write_reg(CSR_SECOND_COLOR, c2);
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      n_settings++;
      area = dim_sat(w) * dim_sat(h);
      for (int i = 0; i < count; i++) begin
         idle_gap();
         x     = $urandom;
         y     = $urandom;
         index = INDEX_W'($urandom);
         f = ($urandom_range(0, 99) < ((m == MODE_IMAGE) ? 25 : 15)) ? FUNC_WRITE : FUNC_SAMPLE;
         if (f == FUNC_WRITE) begin
            if (m == MODE_IMAGE && area > 0 && $urandom_range(0, 9) < 7)
               index = INDEX_W'($urandom_range(0, area - 1));
         end else if (m == MODE_CHECKER && $urandom_range(0, 1) == 1) begin
            // small multiples of powers of two land on zero crossings often
            x = 32'((int'($urandom_range(0, 511)) - 256) <<< $urandom_range(6, 16));
            y = 32'((int'($urandom_range(0, 511)) - 256) <<< $urandom_range(6, 16));
         end else if (m == MODE_IMAGE) begin
            x = span_coord();
            y = span_coord();
         end
         // a lookup only ever reads a texel that has been written
         if (f == FUNC_SAMPLE && m == MODE_IMAGE && area > 0) begin
            target = texel_addr(x, y);
            if (!texel_written[target])
               send_item(FUNC_WRITE, $urandom, $urandom, target, RGB_W'($urandom), 1'b0, '0);
         end
         send_item(f, x, y, index, RGB_W'($urandom), 1'b0, '0);
         if (hold && i == count / 3)
            hold_req = 1'b1;
         if (pause && i == count / 2)
            wait_drained();
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_WRITE;
      req_bus.coord_x     = '0;
      req_bus.coord_y     = '0;
      req_bus.texel_index = '0;
      req_bus.texel_rgb   = '0;
      rsp_bus.ready       = 1'b0;
      quiet               = 1'b0;
      hold_req            = 1'b0;
      hold_left           = 0;
      cycle_count         = 0;
      n_errors            = 0;
      n_checked           = 0;
      n_writes            = 0;
      n_samples           = 0;
      n_settings          = 0;
      cfg_mode            = MODE_SOLID;
      cfg_density         = 16'd256;
      cfg_first           = 24'h000000;
      cfg_second          = 24'hFFFFFF;
      cfg_width           = '0;
      cfg_height          = '0;

      // Directed table: reset values, extremes, zero crossings, clamps, saturation
      add_item(FUNC_SAMPLE, 32'h0, 32'h0, '0, '0, 1'b1, 24'h000000);
      add_item(FUNC_SAMPLE, 32'h80000000, 32'h7FFFFFFF, '0, '0, 1'b1, 24'h000000);
      add_item(FUNC_WRITE, 32'h0, 32'h0, 16'h0000, 24'h000000, 1'b0, '0);
      add_item(FUNC_WRITE, 32'hFFFFFFFF, 32'h0, 16'h0001, 24'hFFFFFF, 1'b0, '0);
      add_item(FUNC_WRITE, 32'h0, 32'hFFFFFFFF, 16'h0002, 24'h0F0F0F, 1'b0, '0);
      add_item(FUNC_WRITE, 32'h0, 32'h0, 16'h0003, 24'hF0F0F0, 1'b0, '0);
      add_item(FUNC_WRITE, 32'h0, 32'h0, 16'hFFFF, 24'h5A5AA5, 1'b0, '0);
      add_reg(CSR_MODE, CSR_DATA_W'(MODE_RED));
      add_item(FUNC_SAMPLE, 32'h12345678, 32'hFFFFFFFF, '0, '0, 1'b1, RED_RGB);
      add_reg(CSR_MODE, CSR_DATA_W'(MODE_CHECKER));
      add_item(FUNC_SAMPLE, 32'h00004000, 32'h0000C000, '0, '0, 1'b1, 24'h000000);
      add_item(FUNC_SAMPLE, 32'h00004000, 32'h00004000, '0, '0, 1'b1, 24'hFFFFFF);
      add_item(FUNC_SAMPLE, 32'h00008000, 32'h0000C000, '0, '0, 1'b1, 24'hFFFFFF);
      add_item(FUNC_SAMPLE, 32'h00000000, 32'h0000C000, '0, '0, 1'b1, 24'hFFFFFF);
      add_item(FUNC_SAMPLE, 32'hFFFFC000, 32'h00004000, '0, '0, 1'b1, 24'h000000);
      add_reg(CSR_FIRST_COLOR, 24'h123456);
      add_reg(CSR_SECOND_COLOR, 24'hABCDEF);
      add_reg(CSR_DENSITY, 24'h00FFFF);
      add_item(FUNC_SAMPLE, 32'h7FFFFFFF, 32'h80000000, '0, '0, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h00010001, 32'hFFFF0003, '0, '0, 1'b0, '0);
      add_reg(CSR_DENSITY, 24'h000000);
      add_item(FUNC_SAMPLE, 32'h00004000, 32'h0000C000, '0, '0, 1'b1, 24'hABCDEF);
      add_reg(CSR_MODE, CSR_DATA_W'(MODE_IMAGE));
      add_item(FUNC_SAMPLE, 32'h0, 32'h0, '0, '0, 1'b1, RED_RGB);
      add_reg(CSR_IMAGE_WIDTH, 24'd2);
      add_item(FUNC_SAMPLE, 32'h0, 32'h0, '0, '0, 1'b1, RED_RGB);
      add_reg(CSR_IMAGE_HEIGHT, 24'd2);
      add_item(FUNC_SAMPLE, 32'h00000000, 32'h00010000, '0, '0, 1'b1, 24'h000000);
      add_item(FUNC_SAMPLE, 32'h00010000, 32'h00000000, '0, '0, 1'b1, 24'hF0F0F0);
      add_item(FUNC_SAMPLE, 32'h80000000, 32'h7FFFFFFF, '0, '0, 1'b1, 24'h000000);
      add_item(FUNC_SAMPLE, 32'h7FFFFFFF, 32'h80000000, '0, '0, 1'b1, 24'hF0F0F0);
      add_item(FUNC_SAMPLE, 32'h00008000, 32'h00008000, '0, '0, 1'b0, '0);
      add_reg(CSR_IMAGE_WIDTH, 24'd511);
      add_reg(CSR_IMAGE_HEIGHT, 24'd511);
      add_item(FUNC_SAMPLE, 32'h00010000, 32'h00000000, '0, '0, 1'b1, 24'h5A5AA5);
      add_item(FUNC_SAMPLE, 32'h00000000, 32'h00010000, '0, '0, 1'b1, 24'h000000);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_REG) begin
            write_reg(dir_rows[i].reg_index, dir_rows[i].reg_data);
         end else begin
            idle_gap();
            send_item(dir_rows[i].func, dir_rows[i].x, dir_rows[i].y, dir_rows[i].index,
                      dir_rows[i].rgb, dir_rows[i].typed, dir_rows[i].colour);
         end
      end

      // Random phases; the first runs with no idling on either side
      quiet = 1'b1;
      run_phase(MODE_SOLID, 16'($urandom), 24'($urandom), 24'($urandom), 9'($urandom),
                9'($urandom), 100, 1'b0, 1'b0);
      quiet = 1'b0;
      run_phase(MODE_CHECKER, 16'h0100, 24'h000000, 24'hFFFFFF, 9'd0, 9'd0, 150, 1'b0, 1'b0);
      run_phase(MODE_CHECKER, 16'hFFFF, 24'($urandom), 24'($urandom), 9'd511, 9'd511, 100,
                1'b0, 1'b0);
      run_phase(MODE_CHECKER, 16'h0000, 24'hFFFFFF, 24'h000000, 9'd1, 9'd1, 50, 1'b0, 1'b0);
      run_phase(MODE_CHECKER, 16'($urandom), 24'($urandom), 24'($urandom), 9'd0, 9'd0, 200,
                1'b1, 1'b0);
      run_phase(MODE_CHECKER, 16'h0001, 24'($urandom), 24'($urandom), 9'd0, 9'd0, 80,
                1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd1, 9'd1, 80,
                1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd2, 9'd3, 150,
                1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd16, 9'd16, 200,
                1'b1, 1'b1);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd300, 9'd256, 80,
                1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd511, 9'd1, 100,
                1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd1, 9'd256, 100,
                1'b0, 1'b1);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom),
                9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)), 100, 1'b0, 1'b0);
      run_phase(MODE_RED, 16'($urandom), 24'($urandom), 24'($urandom), 9'($urandom),
                9'($urandom), 50, 1'b0, 1'b0);
      run_phase(MODE_IMAGE, 16'($urandom), 24'($urandom), 24'($urandom), 9'd0, 9'd7, 30,
                1'b0, 1'b0);

      // Let the last transfers through, then report
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d texel writes and %0d samples over %0d random register settings",
               n_writes, n_samples, n_settings);
      $display("in solid, checker, image and fallback modes; %0d colours compared, %0d errors",
               n_checked, n_errors);
      if (n_errors == 0 && colour_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
hdl/tas_pkg.sv
hdl/tas_if.sv
hdl/tas_front.sv
hdl/tas_queue.sv
hdl/tas_back.sv
hdl/texture_albedo_sampler_core.sv
dv/texture_albedo_sampler_core_tb.sv
